// File: hdl/binary_angle_sine_cosine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary angle sine/cosine block
// Clocked checks on clk, disabled while rst_n is low; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef BINARY_ANGLE_SINE_COSINE_ASSERT_SVH
`define BINARY_ANGLE_SINE_COSINE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BASC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BASC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BASC_ASSERT_NOW(lbl, ante, cons, msg)
`define BASC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hdl/basc_pkg.sv
// ----------------------------------------------------------------------------
// basc_pkg
// Constants, types and the square root step of the Q8 sine/cosine pipeline.
// ----------------------------------------------------------------------------
package basc_pkg;

  localparam int ANGLE_W = 16;
  localparam int TRIG_W  = 10;

  // parabola divisor and its rounded-down reciprocal scaled by 2^RECIP_SHIFT
  localparam logic [19:0] PARA_DIV    = 20'd882673;
  localparam logic [20:0] RECIP_M     = 21'd1245661;
  localparam int          RECIP_SHIFT = 40;

  localparam logic [8:0] Q8_ONE = 9'd256;

  typedef struct packed {
    logic swap_pair;
    logic neg_cos;
    logic neg_sin;
  } quad_t;

  typedef struct packed {
    logic [8:0] rem;
    logic [7:0] root;
  } sqrt_st_t;

  // one digit of a restoring square root: bring down two bits of the radicand
  function automatic sqrt_st_t sqrt_step(sqrt_st_t st, logic [1:0] pair);
    logic [10:0] rem_sh;
    logic [10:0] trial;
    sqrt_st_t    res;
    rem_sh = {st.rem, pair};
    trial  = {1'b0, st.root, 2'b01};
    if (rem_sh >= trial) begin
      rem_sh   = rem_sh - trial;
      res.rem  = rem_sh[8:0];
      res.root = {st.root[6:0], 1'b1};
    end else begin
      res.rem  = rem_sh[8:0];
      res.root = {st.root[6:0], 1'b0};
    end
    return res;
  endfunction

endpackage

// File: hdl/binary_angle_sine_cosine.sv
// ----------------------------------------------------------------------------
// binary_angle_sine_cosine
// Q8 cosine and sine of a 16-bit binary angle, parabola plus square root.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_angle: one angle word, 65536 units
//   per turn, read as two's complement. Result channel out_valid / out_stall
//   with out_cosine and out_sine, signed Q8 (256 = 1.0).
//   A word is taken at a rising edge with valid high and stall low.
//   Throughput: one angle per cycle while the receiver does not stall. Stages:
//   out_valid rises once the word has passed the eight register stages (the
//   first loads at the accepting edge): fold, square, reciprocal multiply,
//   quotient fix and parabola, Q8 square, two square root stages of four
//   digits each, and the output register with swap and signs.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall is raised in the same cycle; nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) clears all stage valid bits; the first
//   angle may be offered in the cycle after reset is released.
//   Near an axis the smaller value bottoms out at 15, not 0.
// ----------------------------------------------------------------------------
module binary_angle_sine_cosine
  import basc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ANGLE_W-1:0]       in_angle,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TRIG_W-1:0] out_cosine,
  output logic signed [TRIG_W-1:0] out_sine
);

  `include "binary_angle_sine_cosine_assert.svh"

  logic adv;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, out_valid_r;

  quad_t q1_r, q2_r, q3_r, q4_r, q5_r, q6_r, q7_r;
  quad_t q1_nxt;

  logic [13:0] ax1_r, ax1_nxt;
  logic [26:0] xx2_r, xx3_r;
  logic [27:0] sq2_nxt;
  logic [47:0] prod3_nxt;
  logic [6:0]  q0_3_r;
  logic [27:0] thr4;
  logic [6:0]  quo4;
  logic [8:0]  c4_r, c5_r, c6_r, c7_r, c4_nxt;
  logic [17:0] cc5;
  logic [8:0]  g5;
  logic [15:0] n5_r, n5_nxt;
  sqrt_st_t    s6_r, s6_nxt, s7_r, s7_nxt;
  logic [7:0]  nlo6_r;
  logic [8:0]  cos_mag, sin_mag;
  logic signed [TRIG_W-1:0] cos_nxt, sin_nxt, cos_r, sin_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // fold into the quadrant around the nearest axis
  always_comb begin
    q1_nxt.swap_pair = in_angle[14] ^ in_angle[13];
    q1_nxt.neg_cos   = in_angle[15] ^ in_angle[14];
    q1_nxt.neg_sin   = in_angle[15];
    ax1_nxt = in_angle[13] ? (14'd0 - in_angle[13:0]) : in_angle[13:0];
  end

  assign sq2_nxt   = ax1_r * ax1_r;
  assign prod3_nxt = xx2_r * RECIP_M;

  // reciprocal quotient may be one short: fix with one compare
  always_comb begin
    thr4   = ({20'd0, q0_3_r} + 27'd1) * PARA_DIV;
    quo4   = q0_3_r + {6'd0, ({1'b0, xx3_r} >= thr4)};
    c4_nxt = Q8_ONE - {2'b00, quo4};
  end

  always_comb begin
    cc5    = c4_r * c4_r;
    g5     = Q8_ONE - cc5[16:8];
    n5_nxt = {g5[7:0], 8'hFF};
  end

  always_comb begin
    sqrt_st_t st;
    st = '0;
    for (int i = 3; i >= 0; i--) begin
      st = sqrt_step(st, n5_r[8 + 2*i +: 2]);
    end
    s6_nxt = st;
  end

  always_comb begin
    sqrt_st_t st;
    st = s6_r;
    for (int i = 3; i >= 0; i--) begin
      st = sqrt_step(st, nlo6_r[2*i +: 2]);
    end
    s7_nxt = st;
  end

  always_comb begin
    cos_mag = q7_r.swap_pair ? {1'b0, s7_r.root} : c7_r;
    sin_mag = q7_r.swap_pair ? c7_r : {1'b0, s7_r.root};
    cos_nxt = q7_r.neg_cos ? (10'sd0 - $signed({1'b0, cos_mag}))
                           : $signed({1'b0, cos_mag});
    sin_nxt = q7_r.neg_sin ? (10'sd0 - $signed({1'b0, sin_mag}))
                           : $signed({1'b0, sin_mag});
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      out_valid_r <= v7_r;
    end
  end

  // payload: advance all stages together, hold on stall
  always_ff @(posedge clk) begin
    if (adv) begin
      q1_r   <= q1_nxt;
      ax1_r  <= ax1_nxt;
      q2_r   <= q1_r;
      xx2_r  <= sq2_nxt[26:0];
      q3_r   <= q2_r;
      xx3_r  <= xx2_r;
      q0_3_r <= prod3_nxt[RECIP_SHIFT +: 7];
      q4_r   <= q3_r;
      c4_r   <= c4_nxt;
      q5_r   <= q4_r;
      c5_r   <= c4_r;
      n5_r   <= n5_nxt;
      q6_r   <= q5_r;
      c6_r   <= c5_r;
      s6_r   <= s6_nxt;
      nlo6_r <= n5_r[7:0];
      q7_r   <= q6_r;
      c7_r   <= c6_r;
      s7_r   <= s7_nxt;
      cos_r  <= cos_nxt;
      sin_r  <= sin_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_cosine = cos_r;
  assign out_sine   = sin_r;

  `BASC_ASSERT_NOW(a_quot_not_high, v3_r,
    ({21'd0, q0_3_r} * {8'd0, PARA_DIV}) <= {1'b0, xx3_r},
    "reciprocal quotient exceeds true quotient")

  `BASC_ASSERT_NOW(a_sqrt_exact, v7_r,
    s7_r.rem <= {s7_r.root, 1'b0},
    "square root remainder too large")

  `BASC_ASSERT_NOW(a_near_axis_range, v5_r,
    (c5_r >= 9'd180) && (c5_r <= Q8_ONE),
    "parabola value out of range")

  `BASC_ASSERT_NEXT(a_stall_freezes, out_valid_r && out_stall,
    $stable(v7_r) && $stable(c7_r) && $stable(s7_r),
    "pipeline moved while output stalled")

endmodule

// File: sim/tb_binary_angle_sine_cosine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_angle_sine_cosine
// Streams binary angles into the Q8 sine/cosine pipeline and checks every
// output word against a bit-exact predictor of the fold, parabola and square
// root path. Both channels idle in random bursts, the receiver holds off once
// long enough to back up the pipe, and the sender drains the pipe once.
// ----------------------------------------------------------------------------
module tb_binary_angle_sine_cosine;
  import basc_pkg::*;

  localparam int unsigned PARABOLA_DIV = 882673;
  localparam int RANDOM_ITEMS = 1800;
  localparam int QUIET_TAIL   = 300;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 200;
  localparam int PAUSE_AT     = 1200;

  typedef struct {
    logic [ANGLE_W-1:0]       angle;
    logic signed [TRIG_W-1:0] cosine;
    logic signed [TRIG_W-1:0] sine;
  } trig_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [ANGLE_W-1:0] in_angle = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic signed [TRIG_W-1:0] out_cosine;
  logic signed [TRIG_W-1:0] out_sine;

  logic [ANGLE_W-1:0] pending_angles[$];
  trig_word_t         expected_words[$];

  int  total_items = 0;
  int  items_sent = 0;
  int  n_accepted = 0;
  int  n_checked = 0;
  int  err_count = 0;
  logic in_taken = 1'b0;
  logic quiet;

  binary_angle_sine_cosine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_angle  (in_angle),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_cosine(out_cosine),
    .out_sine  (out_sine)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // no idling on either side near the end of the run
  assign quiet = (items_sent + QUIET_TAIL >= total_items);

  function automatic trig_word_t sincos_q8(logic [ANGLE_W-1:0] a);
    int          x;
    int unsigned xx;
    int unsigned c;
    int unsigned g;
    int unsigned n;
    int unsigned s;
    int unsigned t;
    int          co;
    int          si;
    trig_word_t  w;
    // fold onto the nearest axis: low 13 bits, bit 13 gives the sign
    x  = int'(a[12:0]) - (a[13] ? 8192 : 0);
    xx = x * x;
    c  = 256 - xx / PARABOLA_DIV;
    g  = 256 - ((c * c) >> 8);
    n  = g * 256 + 255;
    s  = 0;
    for (int k = 7; k >= 0; k--) begin
      t = s | (32'd1 << k);
      if (t * t <= n) s = t;
    end
    if (a[14] ^ a[13]) begin
      co = s;
      si = c;
    end else begin
      co = c;
      si = s;
    end
    if (a[15]) si = -si;
    if (a[15] ^ a[14]) co = -co;
    w.angle  = a;
    w.cosine = co[TRIG_W-1:0];
    w.sine   = si[TRIG_W-1:0];
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  // sender: hold a stalled word, otherwise advance, idle or wait for drain
  logic [ANGLE_W-1:0] next_angle;
  logic next_valid;
  int   send_gap = 0;
  logic drain_wait = 1'b0;
  logic pause_done = 1'b0;

  always @(negedge clk) begin
    if (rst_n) begin
      next_valid = in_valid;
      next_angle = in_angle;
      if (in_valid && in_taken) next_valid = 1'b0;
      if (!next_valid) begin
        if (drain_wait) begin
          if (expected_words.size() == 0) drain_wait = 1'b0;
        end else if (send_gap > 0) begin
          send_gap--;
        end else if (pending_angles.size() != 0) begin
          if (items_sent == PAUSE_AT && !pause_done) begin
            drain_wait = 1'b1;
            pause_done = 1'b1;
          end else if (!quiet && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 15);
          end else begin
            next_angle = pending_angles.pop_front();
            next_valid = 1'b1;
            items_sent <= items_sent + 1;
          end
        end
      end
      in_valid <= next_valid;
      in_angle <= next_angle;
    end
  end

  // receiver: random stall bursts plus one long hold-off
  int   hold_left = 0;
  int   stall_left = 0;
  logic hold_done = 1'b0;
  logic next_stall;

  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        next_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
      end
      out_stall <= next_stall;
    end
  end

  // monitor: check the output word, then record the accepted angle
  trig_word_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word cos=%0d sin=%0d", out_cosine, out_sine));
        end else begin
          want = expected_words.pop_front();
          if (out_cosine !== want.cosine)
            report_mismatch($sformatf("angle %h cosine %0d, want %0d",
                                      want.angle, out_cosine, want.cosine));
          if (out_sine !== want.sine)
            report_mismatch($sformatf("angle %h sine %0d, want %0d",
                                      want.angle, out_sine, want.sine));
        end
        n_checked <= n_checked + 1;
      end
      if (in_valid && !in_stall) begin
        expected_words.push_back(sincos_q8(in_angle));
        n_accepted <= n_accepted + 1;
      end
      in_taken <= in_valid && !in_stall;
    end
  end

  logic [ANGLE_W-1:0] directed[] = '{
    16'h0000, 16'h0001, 16'h1000, 16'h1FFF, 16'h2000, 16'h2001, 16'h3FFF,
    16'h4000, 16'h5FFF, 16'h6000, 16'h7FFF, 16'h8000, 16'h8001, 16'h9FFF,
    16'hA000, 16'hBFFF, 16'hC000, 16'hDFFF, 16'hE000, 16'hE001, 16'hFFFF,
    16'h5555, 16'hAAAA, 16'h0F0F
  };

  initial begin
    logic [ANGLE_W-1:0] a;
    foreach (directed[i]) pending_angles.push_back(directed[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // bias part of the angles toward the fold and axis boundaries
      if ($urandom_range(0, 9) < 3)
        a = 16'($urandom_range(0, 7) * 16'h2000 + $urandom_range(0, 64) - 32);
      else
        a = 16'($urandom_range(0, 65535));
      pending_angles.push_back(a);
    end
    total_items = pending_angles.size();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    do @(negedge clk);
    while (n_accepted != total_items || n_checked != total_items);
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
